@@ rtl/motor_command_line_parser_defines.svh @@
// Assertion macros for the motor command line parser.
// Included by files that check their own logic; relies on clk and rst_n in scope.
`ifndef MOTOR_COMMAND_LINE_PARSER_DEFINES_SVH
`define MOTOR_COMMAND_LINE_PARSER_DEFINES_SVH

// same-cycle implication
`define MCLP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mclp assertion failed");

// next-cycle implication
`define MCLP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mclp assertion failed");

`endif

@@ rtl/mclp_pkg.sv @@
// Shared types, codes and keyword table for the motor command line parser.
// No dependencies.
package mclp_pkg;

  localparam int LINE_MAX_DEF   = 64;
  localparam int TOKENS_MAX_DEF = 8;
  localparam int FRAME_MAX_DEF  = 256;

  localparam int FRM_W = 9;  // holds FRAME_MAX+1 for FRAME_MAX up to 256
  localparam int TOK_W = 4;  // holds TOKENS_MAX up to 15
  localparam int CIT_W = 6;

  localparam logic [2:0] KW_GOTO   = 3'd0;
  localparam logic [2:0] KW_STOP   = 3'd1;
  localparam logic [2:0] KW_STATUS = 3'd2;
  localparam logic [2:0] KW_ALL    = 3'd3;
  localparam logic [2:0] KW_HELP   = 3'd4;
  localparam logic [2:0] KW_INIT   = 3'd5;
  localparam logic [2:0] KW_V      = 3'd6;
  localparam logic [2:0] KW_A      = 3'd7;

  // padded with spaces, padding never compared
  localparam logic [47:0] KW_TEXT [0:7] = '{
    "GOTO  ", "STOP  ", "STATUS", "ALL   ", "HELP  ", "INIT  ", "V     ", "A     "
  };
  localparam logic [CIT_W-1:0] KW_LEN [0:7] = '{
    6'd4, 6'd4, 6'd6, 6'd3, 6'd4, 6'd4, 6'd1, 6'd1
  };

  localparam logic [2:0] FTK_OTHER = 3'd0;
  localparam logic [2:0] FTK_M     = 3'd1;
  localparam logic [2:0] FTK_ALL   = 3'd2;
  localparam logic [2:0] FTK_HELP  = 3'd3;
  localparam logic [2:0] FTK_INIT  = 3'd4;

  localparam logic [1:0] SKW_OTHER  = 2'd0;
  localparam logic [1:0] SKW_GOTO   = 2'd1;
  localparam logic [1:0] SKW_STOP   = 2'd2;
  localparam logic [1:0] SKW_STATUS = 2'd3;

  localparam logic [1:0] PTK_OTHER = 2'd0;
  localparam logic [1:0] PTK_V     = 2'd1;
  localparam logic [1:0] PTK_A     = 2'd2;

  localparam logic [2:0] CMD_NONE    = 3'd0;
  localparam logic [2:0] CMD_GOTO    = 3'd1;
  localparam logic [2:0] CMD_STOP    = 3'd2;
  localparam logic [2:0] CMD_STATUS  = 3'd3;
  localparam logic [2:0] CMD_ALLSTOP = 3'd4;
  localparam logic [2:0] CMD_USAGE   = 3'd5;
  localparam logic [2:0] CMD_SETUP   = 3'd6;

  localparam logic [31:0] MAG_CAP = 32'h8000_0000;

  // one parsed frame, handed from front to back
  typedef struct packed {
    logic [TOK_W-1:0]   tok_cnt;
    logic [2:0]         first_kind;
    logic [1:0]         second_kw;
    logic [3:0]         held_neg;
    logic [3:0][31:0]   held_mag;
  } frame_rec_t;

  function automatic logic [7:0] kw_byte(input logic [2:0] k, input logic [CIT_W-1:0] pos);
    logic [7:0] b;
    b = 8'h00;
    if (pos < 6'd6) b = KW_TEXT[k][8*(5-int'(pos)) +: 8];
    return b;
  endfunction

  // atoi-style saturation of sign and magnitude
  function automatic logic [31:0] num_value(input logic neg, input logic [31:0] mag);
    logic [31:0] v;
    if (neg) v = (mag >= MAG_CAP) ? MAG_CAP : (32'd0 - mag);
    else     v = (mag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag;
    return v;
  endfunction

endpackage

@@ rtl/mclp_front.sv @@
// Front end, uses mclp_pkg: folds, tokenises and classifies one accepted byte per
// cycle, keeps per-frame token state, emits a record on a last byte within FRAME_MAX.
module mclp_front
  import mclp_pkg::*;
#(
  parameter int LINE_MAX   = LINE_MAX_DEF,
  parameter int TOKENS_MAX = TOKENS_MAX_DEF,
  parameter int FRAME_MAX  = FRAME_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] char_byte,
  input  logic       line_end,
  output logic       push,
  output frame_rec_t rec
);

  localparam logic [1:0] PH_LEAD = 2'd0;
  localparam logic [1:0] PH_DIG  = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  logic [FRM_W-1:0] fl_r, fl_nxt;
  logic             ce_r, ce_nxt;
  logic [TOK_W-1:0] tt_r, tt_nxt;
  logic             in_r, in_nxt;
  logic [CIT_W-1:0] cit_r, cit_nxt;
  logic [7:0]       flg_r, flg_nxt;
  logic [1:0]       ph_r, ph_nxt;
  logic             neg_r, neg_nxt;
  logic [31:0]      mag_r, mag_nxt;
  logic [2:0]       ftk_r, ftk_nxt;
  logic [1:0]       skw_r, skw_nxt;
  logic [1:0]       ptk_r, ptk_nxt;
  logic [3:0]       hneg_r, hneg_nxt;
  logic [3:0][31:0] hmag_r, hmag_nxt;

  logic [7:0]       cu;
  logic             brk;
  logic             skip;
  logic             do_end;
  logic [35:0]      m36;
  logic [TOK_W-1:0] idx;
  logic [7:0]       hit;

  always_comb begin
    fl_nxt   = (fl_r <= FRM_W'(FRAME_MAX)) ? fl_r + 1'b1 : fl_r;
    ce_nxt   = ce_r;
    tt_nxt   = tt_r;
    in_nxt   = in_r;
    cit_nxt  = cit_r;
    flg_nxt  = flg_r;
    ph_nxt   = ph_r;
    neg_nxt  = neg_r;
    mag_nxt  = mag_r;
    ftk_nxt  = ftk_r;
    skw_nxt  = skw_r;
    ptk_nxt  = ptk_r;
    hneg_nxt = hneg_r;
    hmag_nxt = hmag_r;
    brk      = 1'b0;
    skip     = 1'b0;
    m36      = '0;
    hit      = '0;
    idx      = '0;
    cu       = (char_byte >= "a" && char_byte <= "z") ? char_byte - 8'd32 : char_byte;

    if (!ce_r && fl_r < FRM_W'(LINE_MAX - 1)) begin
      if (char_byte == 8'd0) begin
        ce_nxt = 1'b1;
        brk    = 1'b1;
      end else if (cu == " " || cu == 8'd13 || cu == 8'd10) begin
        brk = 1'b1;
      end else begin
        if (!in_r && tt_r < TOK_W'(TOKENS_MAX)) begin
          tt_nxt  = tt_r + 1'b1;
          in_nxt  = 1'b1;
          cit_nxt = '0;
          flg_nxt = 8'hFF;
          ph_nxt  = PH_LEAD;
          neg_nxt = 1'b0;
          mag_nxt = '0;
        end
        if (in_nxt) begin
          for (int k = 0; k < 8; k++) begin
            if (cit_nxt >= KW_LEN[k] || kw_byte(3'(k), cit_nxt) != cu) flg_nxt[k] = 1'b0;
          end
          if (tt_nxt == TOK_W'(1) && cit_nxt == '0) begin
            if (cu == "M") ftk_nxt = FTK_M;
          end else begin
            if (ph_nxt == PH_LEAD) begin
              if (cu == 8'd9 || cu == 8'd11 || cu == 8'd12) begin
                skip = 1'b1;
              end else if (cu == "+" || cu == "-") begin
                neg_nxt = (cu == "-");
                ph_nxt  = PH_DIG;
                skip    = 1'b1;
              end else begin
                ph_nxt = PH_DIG;
              end
            end
            if (!skip && ph_nxt == PH_DIG) begin
              if (cu >= "0" && cu <= "9") begin
                m36     = {4'd0, mag_nxt} * 36'd10 + {32'd0, cu[3:0]};
                mag_nxt = (m36 > {4'd0, MAG_CAP}) ? MAG_CAP : m36[31:0];
              end else begin
                ph_nxt = PH_DONE;
              end
            end
          end
          if (cit_nxt < 6'd63) cit_nxt = cit_nxt + 1'b1;
        end
      end
    end

    do_end = in_nxt && (brk || line_end);
    if (do_end) begin
      idx = tt_nxt - 1'b1;
      for (int k = 0; k < 8; k++) hit[k] = flg_nxt[k] && (cit_nxt == KW_LEN[k]);
      if (idx == TOK_W'(0)) begin
        if (ftk_nxt == FTK_M) begin
          hneg_nxt[0] = neg_nxt;
          hmag_nxt[0] = mag_nxt;
        end else if (hit[KW_ALL])  ftk_nxt = FTK_ALL;
        else if (hit[KW_HELP])     ftk_nxt = FTK_HELP;
        else if (hit[KW_INIT])     ftk_nxt = FTK_INIT;
      end else if (idx == TOK_W'(1)) begin
        if (hit[KW_GOTO])        skw_nxt = SKW_GOTO;
        else if (hit[KW_STOP])   skw_nxt = SKW_STOP;
        else if (hit[KW_STATUS]) skw_nxt = SKW_STATUS;
      end else if (idx == TOK_W'(2)) begin
        hneg_nxt[1] = neg_nxt;
        hmag_nxt[1] = mag_nxt;
      end
      if (idx >= TOK_W'(4)) begin
        if (ptk_r == PTK_V) begin
          hneg_nxt[2] = neg_nxt;
          hmag_nxt[2] = mag_nxt;
        end else if (ptk_r == PTK_A) begin
          hneg_nxt[3] = neg_nxt;
          hmag_nxt[3] = mag_nxt;
        end
      end
      if (idx >= TOK_W'(3))
        ptk_nxt = hit[KW_V] ? PTK_V : (hit[KW_A] ? PTK_A : PTK_OTHER);
      in_nxt = 1'b0;
    end
  end

  assign push = acc && line_end && (fl_nxt <= FRM_W'(FRAME_MAX));
  assign rec  = '{tok_cnt: tt_nxt, first_kind: ftk_nxt, second_kw: skw_nxt,
                  held_neg: hneg_nxt, held_mag: hmag_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && line_end)) begin
      fl_r   <= '0;
      ce_r   <= 1'b0;
      tt_r   <= '0;
      in_r   <= 1'b0;
      cit_r  <= '0;
      flg_r  <= 8'hFF;
      ph_r   <= PH_LEAD;
      neg_r  <= 1'b0;
      mag_r  <= '0;
      ftk_r  <= FTK_OTHER;
      skw_r  <= SKW_OTHER;
      ptk_r  <= PTK_OTHER;
      hneg_r <= '0;
      hmag_r <= '0;
    end else if (acc) begin
      fl_r   <= fl_nxt;
      ce_r   <= ce_nxt;
      tt_r   <= tt_nxt;
      in_r   <= in_nxt;
      cit_r  <= cit_nxt;
      flg_r  <= flg_nxt;
      ph_r   <= ph_nxt;
      neg_r  <= neg_nxt;
      mag_r  <= mag_nxt;
      ftk_r  <= ftk_nxt;
      skw_r  <= skw_nxt;
      ptk_r  <= ptk_nxt;
      hneg_r <= hneg_nxt;
      hmag_r <= hmag_nxt;
    end
  end

endmodule

@@ rtl/mclp_fifo.sv @@
// Two-entry queue of frame records between front and back.
// Uses mclp_pkg and the assertion macros header.
`include "motor_command_line_parser_defines.svh"
module mclp_fifo
  import mclp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  frame_rec_t wr_rec,
  input  logic       pop,
  output frame_rec_t rd_rec,
  output logic       not_empty,
  output logic       full
);

  frame_rec_t mem_r [0:1];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign rd_rec    = mem_r[rp_r];
  assign not_empty = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);

  `MCLP_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= 2'd2)
  `MCLP_ASSERT_IMP(a_no_overflow, push, (cnt_r < 2'd2) || pop)
  `MCLP_ASSERT_NXT(a_fill, push && !pop && cnt_r == 2'd1, cnt_r == 2'd2)

endmodule

@@ rtl/mclp_back.sv @@
// Back end: turns a frame record into a command and holds it in the output
// register until taken. Uses mclp_pkg.
module mclp_back
  import mclp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  frame_rec_t   rec,
  input  logic         rec_valid,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [135:0] out_data
);

  logic         vld_r;
  logic [135:0] dat_r;
  logic [2:0]   typ;
  logic [31:0]  mot, tpos, vel, accv;

  always_comb begin
    typ  = CMD_NONE;
    mot  = 32'hFFFF_FFFF;
    tpos = '0;
    vel  = '0;
    accv = '0;
    if (rec.tok_cnt >= TOK_W'(3) && rec.first_kind == FTK_M) begin
      mot = num_value(rec.held_neg[0], rec.held_mag[0]);
      if (rec.second_kw == SKW_GOTO) begin
        typ  = CMD_GOTO;
        tpos = num_value(rec.held_neg[1], rec.held_mag[1]);
        vel  = num_value(rec.held_neg[2], rec.held_mag[2]);
        accv = num_value(rec.held_neg[3], rec.held_mag[3]);
      end
    end else if (rec.tok_cnt == TOK_W'(2) && rec.first_kind == FTK_M) begin
      mot = num_value(rec.held_neg[0], rec.held_mag[0]);
      if (rec.second_kw == SKW_STOP)        typ = CMD_STOP;
      else if (rec.second_kw == SKW_STATUS) typ = CMD_STATUS;
    end else if (rec.tok_cnt == TOK_W'(2) && rec.first_kind == FTK_ALL) begin
      if (rec.second_kw == SKW_STOP) typ = CMD_ALLSTOP;
    end else if (rec.tok_cnt == TOK_W'(1) && rec.first_kind == FTK_HELP) begin
      typ = CMD_USAGE;
    end else if (rec.tok_cnt == TOK_W'(1) && rec.first_kind == FTK_INIT) begin
      typ = CMD_SETUP;
    end
  end

  assign pop = rec_valid && (!vld_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (pop) begin
      vld_r <= 1'b1;
    end else if (out_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) dat_r <= {5'd0, accv, vel, tpos, mot, typ};
  end

  assign out_valid = vld_r;
  assign out_data  = dat_r;

endmodule

@@ rtl/motor_command_line_parser.sv @@
// Motor command line parser: one received byte can be taken every cycle while
// in_tready is high, with no gaps between frames; a frame's command is pushed into
// the queue at the edge that takes its last byte and moves into the output register
// when that register is empty or being taken, which raises out_tvalid. The rate is
// set by the front end, which updates its token state from each byte as it is taken.
// in_tready drops only while the two-entry queue holds two frames, which happens when
// the output register has been waiting to be taken; frames longer than FRAME_MAX give
// no command.
module motor_command_line_parser
  import mclp_pkg::*;
#(
  parameter int LINE_MAX   = LINE_MAX_DEF,
  parameter int TOKENS_MAX = TOKENS_MAX_DEF,
  parameter int FRAME_MAX  = FRAME_MAX_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] char_byte
  input  logic         in_tlast,   // line_end
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata   // [2:0] command_type, [34:3] motor_number,
                                   // [66:35] target_position, [98:67] max_velocity,
                                   // [130:99] acceleration, rest zero
);

  logic       acc, push, pop, not_empty, full;
  frame_rec_t wr_rec, rd_rec;

  assign in_tready = !full;
  assign acc       = in_tvalid && in_tready;

  mclp_front #(
    .LINE_MAX  (LINE_MAX),
    .TOKENS_MAX(TOKENS_MAX),
    .FRAME_MAX (FRAME_MAX)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .char_byte(in_tdata),
    .line_end (in_tlast),
    .push     (push),
    .rec      (wr_rec)
  );

  mclp_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_rec   (wr_rec),
    .pop      (pop),
    .rd_rec   (rd_rec),
    .not_empty(not_empty),
    .full     (full)
  );

  mclp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .rec      (rd_rec),
    .rec_valid(not_empty),
    .pop      (pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (out_tdata)
  );

endmodule

@@ verif/tb_motor_command_line_parser.sv @@
// Self-checking bench for the motor command line parser: random and directed frames
// are streamed in, each decoded command is predicted in the bench and compared.
// Depends on mclp_pkg and motor_command_line_parser.
module tb_motor_command_line_parser;
  import mclp_pkg::*;

  localparam int LINE_LIM  = LINE_MAX_DEF;
  localparam int TOK_LIM   = TOKENS_MAX_DEF;
  localparam int FRAME_LIM = FRAME_MAX_DEF;
  localparam int CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } byte_req_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] motor;
    logic [31:0] target;
    logic [31:0] vel;
    logic [31:0] accel;
  } command_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [135:0] out_tdata;

  motor_command_line_parser dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  byte_req_t pending_bytes[$];
  command_t  expected_cmds[$];
  int        error_count = 0;
  int        cycle_count = 0;
  bit        calm = 1'b0;   // no idling in the last part

  // parser state mirrored from the block
  int          p_len, p_tokens, p_ctok;
  bit          p_ended, p_intok;
  logic [7:0]  p_kwmask;
  int          p_nphase;
  bit          p_nneg;
  logic [31:0] p_nmag;
  int          p_first, p_second, p_prevkey;
  logic [31:0] p_held[4];

  function automatic string kw_str(int k);
    case (k)
      KW_GOTO:   return "GOTO";
      KW_STOP:   return "STOP";
      KW_STATUS: return "STATUS";
      KW_ALL:    return "ALL";
      KW_HELP:   return "HELP";
      KW_INIT:   return "INIT";
      KW_V:      return "V";
      default:   return "A";
    endcase
  endfunction

  task automatic parser_clear();
    p_len = 0; p_ended = 0; p_tokens = 0; p_intok = 0; p_ctok = 0;
    p_kwmask = 8'hFF; p_nphase = 0; p_nneg = 0; p_nmag = 0;
    p_first = FTK_OTHER; p_second = SKW_OTHER; p_prevkey = PTK_OTHER;
    for (int i = 0; i < 4; i++) p_held[i] = 0;
  endtask

  function automatic bit kw_seen(int k);
    string s;
    s = kw_str(k);
    return p_kwmask[k] && p_ctok == s.len();
  endfunction

  function automatic logic [31:0] signed_value();
    if (p_nneg) return (p_nmag >= MAG_CAP) ? MAG_CAP : (32'd0 - p_nmag);
    return (p_nmag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : p_nmag;
  endfunction

  task automatic close_token();
    int idx;
    logic [31:0] v;
    idx = p_tokens - 1;
    v = signed_value();
    if (idx == 0) begin
      if (p_first == FTK_M) p_held[0] = v;
      else if (kw_seen(KW_ALL)) p_first = FTK_ALL;
      else if (kw_seen(KW_HELP)) p_first = FTK_HELP;
      else if (kw_seen(KW_INIT)) p_first = FTK_INIT;
    end else if (idx == 1) begin
      if (kw_seen(KW_GOTO)) p_second = SKW_GOTO;
      else if (kw_seen(KW_STOP)) p_second = SKW_STOP;
      else if (kw_seen(KW_STATUS)) p_second = SKW_STATUS;
    end else if (idx == 2) begin
      p_held[1] = v;
    end
    if (idx >= 4) begin
      if (p_prevkey == PTK_V) p_held[2] = v;
      else if (p_prevkey == PTK_A) p_held[3] = v;
    end
    if (idx >= 3) p_prevkey = kw_seen(KW_V) ? PTK_V : (kw_seen(KW_A) ? PTK_A : PTK_OTHER);
    p_intok = 0;
  endtask

  task automatic token_byte(logic [7:0] c);
    string s;
    bit skip;
    logic [63:0] m;
    skip = 0;
    for (int k = 0; k < 8; k++) begin
      s = kw_str(k);
      if (p_ctok >= s.len() || s[p_ctok] != c) p_kwmask[k] = 1'b0;
    end
    if (p_tokens == 1 && p_ctok == 0) begin
      if (c == "M") p_first = FTK_M;
    end else begin
      if (p_nphase == 0) begin
        if (c == 8'd9 || c == 8'd11 || c == 8'd12) begin
          skip = 1;
        end else if (c == "+" || c == "-") begin
          p_nneg = (c == "-"); p_nphase = 1; skip = 1;
        end else p_nphase = 1;
      end
      if (!skip && p_nphase == 1) begin
        if (c >= "0" && c <= "9") begin
          m = 64'(p_nmag) * 10 + 64'(c - "0");
          p_nmag = (m > 64'(MAG_CAP)) ? MAG_CAP : m[31:0];
        end else p_nphase = 2;
      end
    end
    if (p_ctok < 63) p_ctok++;
  endtask

  // takes one byte request, pushes a command when a frame within FRAME_LIM ends
  task automatic predict_byte(byte_req_t r);
    int idx;
    logic [7:0] c;
    command_t e;
    idx = p_len;
    c = r.ch;
    if (p_len <= FRAME_LIM) p_len++;
    if (!p_ended && idx < LINE_LIM - 1) begin
      if (c == 0) begin
        p_ended = 1;
        if (p_intok) close_token();
      end else begin
        if (c >= "a" && c <= "z") c -= 32;
        if (c == " " || c == 8'd13 || c == 8'd10) begin
          if (p_intok) close_token();
        end else begin
          if (!p_intok && p_tokens < TOK_LIM) begin
            p_tokens++; p_intok = 1; p_ctok = 0; p_kwmask = 8'hFF;
            p_nphase = 0; p_nneg = 0; p_nmag = 0;
          end
          if (p_intok) token_byte(c);
        end
      end
    end
    if (!r.last) return;
    if (p_len > FRAME_LIM) begin
      parser_clear();
      return;
    end
    if (p_intok) close_token();
    e = '{CMD_NONE, 32'hFFFF_FFFF, 0, 0, 0};
    if (p_tokens >= 3 && p_first == FTK_M) begin
      e.motor = p_held[0];
      if (p_second == SKW_GOTO) begin
        e.cmd = CMD_GOTO; e.target = p_held[1]; e.vel = p_held[2]; e.accel = p_held[3];
      end
    end else if (p_tokens == 2 && p_first == FTK_M) begin
      e.motor = p_held[0];
      if (p_second == SKW_STOP) e.cmd = CMD_STOP;
      else if (p_second == SKW_STATUS) e.cmd = CMD_STATUS;
    end else if (p_tokens == 2 && p_first == FTK_ALL) begin
      if (p_second == SKW_STOP) e.cmd = CMD_ALLSTOP;
    end else if (p_tokens == 1 && p_first == FTK_HELP) e.cmd = CMD_USAGE;
    else if (p_tokens == 1 && p_first == FTK_INIT) e.cmd = CMD_SETUP;
    expected_cmds.push_back(e);
    parser_clear();
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
  endtask

  // driver
  int in_idle = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_byte('{in_tdata, in_tlast});
      if (!in_tvalid || in_tready) begin
        if (in_idle > 0) begin
          in_idle <= in_idle - 1;
          in_tvalid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          byte_req_t r;
          r = pending_bytes.pop_front();
          in_tvalid <= 1'b1; in_tdata <= r.ch; in_tlast <= r.last;
          if (!calm && $urandom_range(0, 19) == 0) in_idle <= $urandom_range(1, 14);
        end else in_tvalid <= 1'b0;
      end
    end
  end

  // monitor and sink stalls
  int out_idle = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        command_t got, want;
        got.cmd = out_tdata[2:0];     got.motor = out_tdata[34:3];
        got.target = out_tdata[66:35]; got.vel = out_tdata[98:67];
        got.accel = out_tdata[130:99];
        if (expected_cmds.size() == 0) begin
          error_count++;
          $display("unexpected command at cycle %0d", cycle_count);
        end else begin
          want = expected_cmds.pop_front();
          if (got.cmd !== want.cmd)
            report_mismatch("command_type", 32'(got.cmd), 32'(want.cmd));
          if (got.motor !== want.motor) report_mismatch("motor_number", got.motor, want.motor);
          if (got.target !== want.target)
            report_mismatch("target_position", got.target, want.target);
          if (got.vel !== want.vel) report_mismatch("max_velocity", got.vel, want.vel);
          if (got.accel !== want.accel) report_mismatch("acceleration", got.accel, want.accel);
        end
      end
      if (out_idle > 0) begin
        out_idle <= out_idle - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!calm && $urandom_range(0, 14) == 0) out_idle <= $urandom_range(1, 14);
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_text(string s, bit last_at_end = 1);
    for (int i = 0; i < s.len(); i++)
      pending_bytes.push_back('{s[i], last_at_end && i == s.len() - 1});
  endtask

  function automatic string rand_number();
    string s;
    int n;
    s = "";
    case ($urandom_range(0, 7))
      0: s = "-";
      1: s = "+";
      2: s = "\t";
      default: ;
    endcase
    n = $urandom_range(0, 3) == 0 ? $urandom_range(0, 12) : $urandom_range(1, 4);
    for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
    if ($urandom_range(0, 9) == 0) s = {s, $urandom_range(0, 1) ? "x" : "-"};
    return s;
  endfunction

  function automatic string rand_sep();
    case ($urandom_range(0, 5))
      0: return "\r";
      1: return "\n";
      2: return "  ";
      default: return " ";
    endcase
  endfunction

  function automatic string mixcase(string s);
    string t;
    t = s;
    for (int i = 0; i < t.len(); i++)
      if (t[i] >= "A" && t[i] <= "Z" && $urandom_range(0, 1)) t[i] = t[i] + 32;
    return t;
  endfunction

  function automatic string rand_frame();
    string s;
    int k;
    k = $urandom_range(0, 9);
    if (k <= 3) begin
      s = {mixcase("M"), rand_number(), rand_sep(), mixcase("GOTO"), rand_sep(), rand_number()};
      repeat ($urandom_range(0, 3))
        s = {s, rand_sep(), mixcase($urandom_range(0, 1) ? "V" : "A"), rand_sep(), rand_number()};
    end else if (k == 4) s = {"M", rand_number(), rand_sep(), mixcase("STOP")};
    else if (k == 5) s = {"m", rand_number(), rand_sep(), mixcase("STATUS")};
    else if (k == 6) s = {mixcase("ALL"), rand_sep(), mixcase("STOP")};
    else if (k == 7) s = $urandom_range(0, 1) ? mixcase("HELP") : mixcase("INIT");
    else begin
      s = "";
      repeat ($urandom_range(1, 12)) s = {s, string'(8'($urandom_range(0, 255)))};
    end
    if ($urandom_range(0, 7) == 0) s = {s, rand_sep()};
    return s;
  endfunction

  initial begin
    string longline;
    parser_clear();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed frames
    push_text("M1 GOTO 100 V 20 A 30");
    push_text("m2 goto -5 v 1 v 7 a 3 a -9");
    push_text("M3 STOP");
    push_text("M4 STATUS");
    push_text("ALL STOP");
    push_text("HELP");
    push_text("INIT");
    push_text("M GOTO 99999999999 V -99999999999 A 2147483648");
    push_text("M5 GOTO -2147483648 V 2147483647");
    push_text("X1 STOP");
    push_text("M1 FOO");
    push_text("M1");
    push_text("HELP ME");
    push_text("M1 GOTO 1 V 2 A 3 X 4 V 5 A 6 A 7");
    pending_bytes.push_back('{8'h00, 1'b1});
    push_text("M7 STOP", 0);
    pending_bytes.push_back('{8'h00, 1'b0});
    push_text(" garbage", 1);
    push_text("M8\tGOTO\v12\f");
    push_text("m1 goto \t+42\r\n");
    push_text("M2 GOTO 5+3 V 7-1");
    longline = "M1 GOTO 5 ";
    while (longline.len() < 66) longline = {longline, "A 9 "};
    push_text(longline);
    // one byte over the frame limit: no command
    longline = "";
    repeat (FRAME_LIM + 1) longline = {longline, "Z"};
    push_text(longline);
    pending_bytes.push_back('{8'hFF, 1'b1});

    // sender holds back until the block has drained
    wait (pending_bytes.size() == 0 && !in_tvalid && expected_cmds.size() == 0);
    repeat (10) @(posedge clk);

    for (int n = 0; n < 10; n++) begin
      push_text(rand_frame());
      if (n == 6) begin
        wait (pending_bytes.size() == 0);
        calm = 1'b1;
      end
    end
    wait (pending_bytes.size() == 0 && !in_tvalid && expected_cmds.size() == 0);
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_cmds.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
